// File: hw/rtl/dlgc_pkg.sv
// Shared types, constants and helpers for the limited DSATUR coloring unit.
package dlgc_pkg;

    localparam int MAX_NODES_DEF = 64;
    localparam int NODE_W        = 6;
    localparam int CNT_W         = 7;
    localparam int ROW_W         = 64;
    localparam int CFG_DW        = 32;
    localparam int CFG_AW        = 3;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_START = 1'b1;

    localparam logic REG_NODE_COUNT  = 1'b0;
    localparam logic REG_COLOR_LIMIT = 1'b1;

    localparam logic [CNT_W-1:0] NODE_COUNT_RST  = 7'd64;
    localparam logic [CNT_W-1:0] COLOR_LIMIT_RST = 7'd64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEL,
        ST_TOKLD,
        ST_COUNT,
        ST_MINP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic              req_type;
        logic [NODE_W-1:0] node;
        logic              is_word;
        logic [ROW_W-1:0]  neighbors;
    } in_beat_t;

    typedef struct packed {
        logic [NODE_W-1:0] colored_node;
        logic [NODE_W-1:0] color;
        logic [CNT_W-1:0]  colors_used;
        logic              node_valid;
        logic              last;
    } out_beat_t;

    // best-candidate token moving down the node chain
    typedef struct packed {
        logic              vld;
        logic [CNT_W-1:0]  key;
        logic [CNT_W-1:0]  cnt;
        logic [NODE_W-1:0] idx;
        logic [ROW_W-1:0]  row;
    } sel_t;

    // neighbor color token moving down the node chain
    typedef struct packed {
        logic              vld;
        logic [NODE_W-1:0] color;
    } tok_t;

    // lowest-count color moving down the color chain
    typedef struct packed {
        logic              vld;
        logic [CNT_W-1:0]  cnt;
        logic [NODE_W-1:0] idx;
    } minc_t;

    typedef struct packed {
        logic              load;
        logic [NODE_W-1:0] load_node;
        logic              load_word;
        logic [ROW_W-1:0]  load_row;
        logic [CNT_W-1:0]  load_pc;
        logic              start_clr;
        logic              first;
        logic [CNT_W-1:0]  n_lim;
        logic              tok_ld;
        logic              tok_shift;
        logic              upd;
        logic [NODE_W-1:0] upd_node;
        logic [NODE_W-1:0] upd_color;
    } node_ctl_t;

    typedef struct packed {
        logic              clr;
        logic              inc_vld;
        logic [NODE_W-1:0] inc_color;
        logic [CNT_W-1:0]  open;
    } color_ctl_t;

    function automatic logic [CNT_W-1:0] popcount64(input logic [ROW_W-1:0] v);
        logic [3:0]       part [8];
        logic [CNT_W-1:0] total;
        total = '0;
        for (int b = 0; b < 8; b++)
        begin
            part[b] = '0;
            for (int k = 0; k < 8; k++)
            begin
                part[b] = part[b] + {3'b000, v[b*8+k]};
            end
        end
        for (int b = 0; b < 8; b++)
        begin
            total = total + {3'b000, part[b]};
        end
        return total;
    endfunction

endpackage

// File: hw/rtl/dlgc_node_cell.sv
// One graph node: row, word flag, color, saturation set and its chain stages.
module dlgc_node_cell #(
    parameter int IDX = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  dlgc_pkg::node_ctl_t ctl,
    input  logic [63:0]         cur_row,
    input  dlgc_pkg::sel_t      sel_in,
    output dlgc_pkg::sel_t      sel_out,
    input  dlgc_pkg::tok_t      tok_in,
    output dlgc_pkg::tok_t      tok_out
);
    import dlgc_pkg::*;

    localparam logic [NODE_W-1:0] MY_IDX = NODE_W'(IDX);

    logic [ROW_W-1:0]  row_reg;
    logic [CNT_W-1:0]  pc_reg;
    logic [NODE_W-1:0] color_reg;
    logic              word_reg;
    logic              done_reg;
    logic [ROW_W-1:0]  satm_reg;
    logic [CNT_W-1:0]  sat_reg;
    sel_t              sel_reg, sel_next;
    tok_t              tok_reg, tok_next;

    logic              cand;
    logic [CNT_W-1:0]  key;

    always_comb
    begin
        cand = word_reg && !done_reg && (CNT_W'(IDX) < ctl.n_lim);
        key  = ctl.first ? pc_reg : sat_reg;
        sel_next     = sel_in;
        sel_next.cnt = sel_in.cnt + {{(CNT_W-1){1'b0}}, cand};
        if (cand && (!sel_in.vld || key > sel_in.key))
        begin
            sel_next.vld = 1'b1;
            sel_next.key = key;
            sel_next.idx = MY_IDX;
            sel_next.row = row_reg;
        end
        if (ctl.tok_ld)
        begin
            tok_next.vld   = done_reg && cur_row[IDX];
            tok_next.color = color_reg;
        end
        else if (ctl.tok_shift)
        begin
            tok_next = tok_in;
        end
        else
        begin
            tok_next = tok_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= 1'b0;
            done_reg <= 1'b0;
            satm_reg <= '0;
            sat_reg  <= '0;
            sel_reg  <= '0;
            tok_reg  <= '0;
        end
        else
        begin
            sel_reg <= sel_next;
            tok_reg <= tok_next;
            if (ctl.load && ctl.load_node == MY_IDX)
            begin
                word_reg <= ctl.load_word;
            end
            if (ctl.start_clr)
            begin
                done_reg <= 1'b0;
                satm_reg <= '0;
                sat_reg  <= '0;
            end
            else if (ctl.upd)
            begin
                if (ctl.upd_node == MY_IDX)
                begin
                    done_reg <= 1'b1;
                end
                if (row_reg[ctl.upd_node] && !satm_reg[ctl.upd_color])
                begin
                    satm_reg[ctl.upd_color] <= 1'b1;
                    sat_reg                 <= sat_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load && ctl.load_node == MY_IDX)
        begin
            row_reg <= ctl.load_row;
            pc_reg  <= ctl.load_pc;
        end
        if (ctl.upd && ctl.upd_node == MY_IDX)
        begin
            color_reg <= ctl.upd_color;
        end
    end

    assign sel_out = sel_reg;
    assign tok_out = tok_reg;

endmodule

// File: hw/rtl/dlgc_color_cell.sv
// One color: conflict counter for the current node and its min-search stage.
module dlgc_color_cell #(
    parameter int IDX = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dlgc_pkg::color_ctl_t ctl,
    input  dlgc_pkg::minc_t      min_in,
    output dlgc_pkg::minc_t      min_out
);
    import dlgc_pkg::*;

    localparam logic [NODE_W-1:0] MY_IDX = NODE_W'(IDX);

    logic [CNT_W-1:0] cnt_reg;
    minc_t            min_reg, min_next;

    always_comb
    begin
        min_next = min_in;
        if ((CNT_W'(IDX) < ctl.open) && (!min_in.vld || cnt_reg < min_in.cnt))
        begin
            min_next.vld = 1'b1;
            min_next.cnt = cnt_reg;
            min_next.idx = MY_IDX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            min_reg <= '0;
        end
        else
        begin
            min_reg <= min_next;
            if (ctl.clr)
            begin
                cnt_reg <= '0;
            end
            else if (ctl.inc_vld && ctl.inc_color == MY_IDX)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    assign min_out = min_reg;

endmodule

// File: hw/rtl/dsatur_limited_graph_coloring_unit.sv
// Top level of the limited DSATUR coloring unit: config port, sequencer, cell chains.
//
//  channel | direction | handshake                  | beat
//  --------+-----------+----------------------------+-----------------------------
//  in      | into unit | in_valid / in_stall        | in_beat_t: load row or start
//  out     | out of    | out_valid / out_stall      | out_beat_t: colored node or empty last
//  cfg     | into unit | psel/penable/pwrite/pready | node_count, color_limit
//
// A load beat is taken in the idle state. A start colors one node per pass: a select
// pass (the first ranks by row popcount), a neighbor-color shift, a color min pass
// and an emit step.
// Reset clears state, the word mask and the config registers to 64/64.
// A stalled output beat holds the sequencer in its emit step.
module dsatur_limited_graph_coloring_unit #(
    parameter int MAX_NODES = dlgc_pkg::MAX_NODES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  dlgc_pkg::in_beat_t          in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output dlgc_pkg::out_beat_t         out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dlgc_pkg::CFG_AW-1:0] paddr,
    input  logic [dlgc_pkg::CFG_DW-1:0] pwdata,
    output logic [dlgc_pkg::CFG_DW-1:0] prdata,
    output logic                        pready
);
    import dlgc_pkg::*;

    localparam int PH_W = $clog2(MAX_NODES + 1);
    localparam logic [PH_W-1:0]  PH_END = PH_W'(MAX_NODES);
    localparam logic [PH_W-1:0]  PH_CNT = PH_W'(MAX_NODES - 1);
    localparam logic [CNT_W-1:0] N_MAX  = CNT_W'(MAX_NODES);

    state_t            state_reg, state_next;
    logic [PH_W-1:0]   cnt_reg, cnt_next;
    logic              first_reg, first_next;
    logic [CNT_W-1:0]  open_reg, open_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [NODE_W-1:0] cur_reg, cur_next;
    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    out_beat_t         res_reg, res_next;
    logic              out_valid_reg, out_valid_next;
    out_beat_t         out_reg, out_next;
    logic [CNT_W-1:0]  nc_reg, cl_reg;

    sel_t       sel_chain [MAX_NODES+1];
    tok_t       tok_chain [MAX_NODES+1];
    minc_t      min_chain [MAX_NODES+1];
    node_ctl_t  nctl;
    color_ctl_t cctl;

    logic              in_acc;
    logic              out_free;
    logic              cfg_wr;
    logic [CNT_W-1:0]  n_lim;
    logic [CNT_W-1:0]  limit_eff;
    logic              use_min;
    logic [NODE_W-1:0] col;
    sel_t              sel_tail;
    minc_t             min_tail;
    tok_t              tok_tail;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_COLOR_LIMIT) ? {{(CFG_DW-CNT_W){1'b0}}, cl_reg}
                                                  : {{(CFG_DW-CNT_W){1'b0}}, nc_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nc_reg <= NODE_COUNT_RST;
            cl_reg <= COLOR_LIMIT_RST;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_NODE_COUNT)
            begin
                nc_reg <= pwdata[CNT_W-1:0];
            end
            else
            begin
                cl_reg <= pwdata[CNT_W-1:0];
            end
        end
    end

    assign n_lim     = (nc_reg > N_MAX) ? N_MAX : nc_reg;
    assign limit_eff = (cl_reg == '0) ? 7'd1 : cl_reg;

    assign sel_chain[0] = '0;
    assign tok_chain[0] = '0;
    assign min_chain[0] = '0;
    assign sel_tail = sel_chain[MAX_NODES];
    assign tok_tail = tok_chain[MAX_NODES];
    assign min_tail = min_chain[MAX_NODES];

    for (genvar g = 0; g < MAX_NODES; g++)
    begin : g_cells
        dlgc_node_cell #(.IDX(g)) u_node (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (nctl),
            .cur_row (cur_row_reg),
            .sel_in  (sel_chain[g]),
            .sel_out (sel_chain[g+1]),
            .tok_in  (tok_chain[g]),
            .tok_out (tok_chain[g+1])
        );
        dlgc_color_cell #(.IDX(g)) u_color (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (cctl),
            .min_in  (min_chain[g]),
            .min_out (min_chain[g+1])
        );
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign use_min = (open_reg != '0) && min_tail.vld
                     && (min_tail.cnt == '0 || open_reg >= limit_eff);
    assign col     = use_min ? min_tail.idx : open_reg[NODE_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg + PH_W'(1);
        first_next     = first_reg;
        open_next      = open_reg;
        rem_next       = rem_reg;
        cur_next       = cur_reg;
        cur_row_next   = cur_row_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;

        nctl           = '0;
        nctl.load_node = in_data.node;
        nctl.load_word = in_data.is_word;
        nctl.load_row  = in_data.neighbors;
        nctl.load_pc   = popcount64(in_data.neighbors);
        nctl.first     = first_reg;
        nctl.n_lim     = n_lim;
        nctl.upd_node  = cur_reg;
        nctl.upd_color = col;

        cctl           = '0;
        cctl.inc_vld   = tok_tail.vld;
        cctl.inc_color = tok_tail.color;
        cctl.open      = open_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (in_data.req_type == REQ_LOAD)
                    begin
                        nctl.load = 1'b1;
                    end
                    else
                    begin
                        nctl.start_clr = 1'b1;
                        open_next      = '0;
                        first_next     = 1'b1;
                        cnt_next       = '0;
                        state_next     = ST_SEL;
                    end
                end
            end
            ST_SEL:
            begin
                if (cnt_reg == PH_END)
                begin
                    if (!sel_tail.vld)
                    begin
                        res_next   = '0;
                        res_next.last = 1'b1;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        if (first_reg)
                        begin
                            rem_next = sel_tail.cnt;
                        end
                        cur_next     = sel_tail.idx;
                        cur_row_next = sel_tail.row;
                        state_next   = ST_TOKLD;
                    end
                end
            end
            ST_TOKLD:
            begin
                nctl.tok_ld = 1'b1;
                cctl.clr    = 1'b1;
                cctl.inc_vld = 1'b0;
                cnt_next    = '0;
                state_next  = ST_COUNT;
            end
            ST_COUNT:
            begin
                nctl.tok_shift = 1'b1;
                if (cnt_reg == PH_CNT)
                begin
                    cnt_next   = '0;
                    state_next = ST_MINP;
                end
            end
            ST_MINP:
            begin
                if (cnt_reg == PH_END)
                begin
                    nctl.upd  = 1'b1;
                    open_next = use_min ? open_reg : open_reg + CNT_W'(1);
                    rem_next  = rem_reg - CNT_W'(1);
                    res_next.colored_node = cur_reg;
                    res_next.color        = col;
                    res_next.colors_used  = use_min ? open_reg : open_reg + CNT_W'(1);
                    res_next.node_valid   = 1'b1;
                    res_next.last         = (rem_reg == 7'd1);
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = res_reg;
                    first_next     = 1'b0;
                    cnt_next       = '0;
                    state_next     = res_reg.last ? ST_IDLE : ST_SEL;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            first_reg     <= 1'b0;
            open_reg      <= '0;
            rem_reg       <= '0;
            cur_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            first_reg     <= first_next;
            open_reg      <= open_next;
            rem_reg       <= rem_next;
            cur_reg       <= cur_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_row_reg <= cur_row_next;
        res_reg     <= res_next;
        out_reg     <= out_next;
    end

    a_color_open: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.node_valid) |-> (out_reg.color < out_reg.colors_used))
        else $error("emitted color not below open color count");

    a_rem_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MINP) |-> (rem_reg != '0))
        else $error("coloring step with no node left");

    a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_EMIT))
        else $error("output beat raised outside emit step");

endmodule

// File: tb/tb_top.sv
// Testbench for the limited DSATUR coloring unit: directed and random runs against a predictor.
module tb_top;
    import dlgc_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_beat_t    in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_beat_t   out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [CFG_AW-1:0] paddr = '0;
    logic [CFG_DW-1:0] pwdata = '0;
    logic [CFG_DW-1:0] prdata;
    logic        pready;

    dsatur_limited_graph_coloring_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // predictor state
    logic [63:0] adj_rows [64];
    logic [63:0] word_bits;
    logic [5:0]  color_of [64];
    int          cfg_nodes;
    int          cfg_limit;

    out_beat_t   colorings_due [$];
    int          fail_cnt = 0;
    bit          quiet_tail = 1'b0;
    int          hold_cycles = 0;

    function automatic int ones64(logic [63:0] v);
        int c;
        c = 0;
        for (int k = 0; k < 64; k++)
            c += v[k];
        return c;
    endfunction

    function automatic void predict_coloring();
        int          n, lim, opened, best, cur, sat, minc, mind, col;
        logic [63:0] words, remaining, done, seen;
        int          cnt [64];
        out_beat_t   r;
        n = (cfg_nodes > 64) ? 64 : cfg_nodes;
        lim = (cfg_limit == 0) ? 1 : cfg_limit;
        words = '0;
        for (int i = 0; i < n; i++)
            words[i] = word_bits[i];
        done = '0;
        opened = 0;
        if (words == '0)
        begin
            r = '0;
            r.last = 1'b1;
            colorings_due = {colorings_due, r};
            return;
        end
        best = -1;
        cur = 0;
        for (int i = 0; i < n; i++)
            if (words[i] && ones64(adj_rows[i]) > best)
            begin
                best = ones64(adj_rows[i]);
                cur = i;
            end
        remaining = words;
        while (remaining != '0)
        begin
            for (int c = 0; c < 64; c++)
                cnt[c] = 0;
            for (int j = 0; j < 64; j++)
                if (adj_rows[cur][j] && done[j])
                    cnt[color_of[j]]++;
            minc = 1 << 30;
            mind = 0;
            for (int c = 0; c < opened && c < 64; c++)
                if (cnt[c] < minc)
                begin
                    minc = cnt[c];
                    mind = c;
                end
            if (opened > 0 && (minc == 0 || opened >= lim))
                col = mind;
            else
            begin
                col = opened;
                opened++;
            end
            color_of[cur] = col[5:0];
            done[cur] = 1'b1;
            remaining[cur] = 1'b0;
            r.colored_node = cur[5:0];
            r.color = col[5:0];
            r.colors_used = opened[6:0];
            r.node_valid = 1'b1;
            r.last = (remaining == '0);
            colorings_due = {colorings_due, r};
            best = -1;
            for (int i = 0; i < n; i++)
                if (remaining[i])
                begin
                    seen = '0;
                    for (int j = 0; j < 64; j++)
                        if (adj_rows[i][j] && done[j])
                            seen[color_of[j]] = 1'b1;
                    sat = ones64(seen);
                    if (sat > best)
                    begin
                        best = sat;
                        cur = i;
                    end
                end
        end
    endfunction

    // in_valid stays high after the accepting edge; the next beat or an idle drops it
    task automatic send_beat(input in_beat_t b);
        bit taken;
        if (quiet_tail == 1'b0 && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= b;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
        if (b.req_type == REQ_LOAD)
        begin
            adj_rows[b.node] = b.neighbors;
            word_bits[b.node] = b.is_word;
        end
        else
            predict_coloring();
    endtask

    task automatic load_row(input int nd, input bit w, input logic [63:0] row);
        in_beat_t b;
        b.req_type = REQ_LOAD;
        b.node = nd[5:0];
        b.is_word = w;
        b.neighbors = row;
        send_beat(b);
    endtask

    task automatic start_run();
        in_beat_t b;
        b.req_type = REQ_START;
        b.node = NODE_W'($urandom());
        b.is_word = 1'($urandom());
        b.neighbors = {$urandom(), $urandom()};
        send_beat(b);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (colorings_due.size() != 0)
            @(posedge clk);
        repeat (800) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input int val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_NODE_COUNT)
            cfg_nodes = val & 127;
        else
            cfg_limit = val & 127;
        @(posedge clk);
    endtask

    // loads a random graph of a given size; rows also carry stray high bits
    task automatic random_graph(input int n, input int density);
        logic [63:0] row;
        for (int i = 0; i < n; i++)
        begin
            row = '0;
            for (int j = 0; j < 64; j++)
                row[j] = ($urandom_range(0, 99) < density);
            load_row(i, ($urandom_range(0, 9) != 0), row);
        end
    endtask

    task automatic test_directed();
        write_reg(REG_NODE_COUNT, 4);
        write_reg(REG_COLOR_LIMIT, 64);
        for (int i = 0; i < 4; i++)
            load_row(i, 1'b0, '0);
        start_run();
        load_row(0, 1'b1, 64'h0000_0000_0000_000E);
        load_row(1, 1'b1, 64'h0000_0000_0000_000D);
        load_row(2, 1'b1, 64'h0000_0000_0000_000B);
        load_row(3, 1'b1, 64'h0000_0000_0000_0007);
        start_run();
        drain();
        write_reg(REG_COLOR_LIMIT, 0);
        start_run();
        drain();
        write_reg(REG_COLOR_LIMIT, 2);
        load_row(2, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
        start_run();
        drain();
        write_reg(REG_NODE_COUNT, 0);
        start_run();
        drain();
        write_reg(REG_NODE_COUNT, 127);
        write_reg(REG_COLOR_LIMIT, 127);
        for (int i = 4; i < 64; i++)
            word_bits[i] = 1'b0;
        for (int i = 4; i < 64; i++)
            if (i == 4 || i == 63)
                load_row(i, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
        load_row(2, 1'b1, 64'h8000_0000_0000_0000);
        start_run();
        drain();
    endtask

    task automatic test_random_small();
        int n;
        for (int k = 0; k < 5; k++)
        begin
            n = $urandom_range(1, 10);
            write_reg(REG_NODE_COUNT, n);
            write_reg(REG_COLOR_LIMIT, $urandom_range(0, 5));
            for (int i = 0; i < 64; i++)
                word_bits[i] = 1'b0;
            random_graph(n, $urandom_range(10, 70));
            for (int i = n; i < 64; i++)
                if (word_bits[i] == 1'b0)
                    load_row(i, 1'b0, {$urandom(), $urandom()});
                else
                    load_row(i, 1'b0, '0);
            start_run();
            if ($urandom_range(0, 1))
                start_run();
            drain();
        end
    endtask

    task automatic test_backpressure();
        write_reg(REG_NODE_COUNT, 8);
        write_reg(REG_COLOR_LIMIT, 3);
        random_graph(8, 50);
        hold_cycles = 3000;
        start_run();
        start_run();
        start_run();
        drain();
    endtask

    task automatic test_full_size();
        write_reg(REG_NODE_COUNT, 64);
        write_reg(REG_COLOR_LIMIT, 64);
        random_graph(64, 30);
        start_run();
        drain();
        write_reg(REG_COLOR_LIMIT, 1);
        quiet_tail = 1'b1;
        start_run();
        drain();
    endtask

    initial
    begin
        for (int i = 0; i < 64; i++)
        begin
            adj_rows[i] = '0;
            color_of[i] = '0;
        end
        word_bits = '0;
        cfg_nodes = 64;
        cfg_limit = 64;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_small();
        test_backpressure();
        test_full_size();
        if (fail_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else if (quiet_tail)
            out_stall <= 1'b0;
        else if (out_stall == 1'b0 && $urandom_range(0, 7) == 0)
            out_stall <= 1'b1;
        else if (out_stall && $urandom_range(0, 9) == 0)
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        out_beat_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (colorings_due.size() == 0)
            begin
                $error("unexpected beat node=%0d", out_data.colored_node);
                fail_cnt++;
            end
            else
            begin
                e = colorings_due.pop_front();
                if (e.colored_node !== out_data.colored_node)
                begin
                    $error("colored_node exp %0d got %0d", e.colored_node,
                        out_data.colored_node);
                    fail_cnt++;
                end
                if (e.color !== out_data.color)
                begin
                    $error("color exp %0d got %0d", e.color, out_data.color);
                    fail_cnt++;
                end
                if (e.colors_used !== out_data.colors_used)
                begin
                    $error("colors_used exp %0d got %0d", e.colors_used,
                        out_data.colors_used);
                    fail_cnt++;
                end
                if (e.node_valid !== out_data.node_valid)
                begin
                    $error("node_valid exp %0d got %0d", e.node_valid,
                        out_data.node_valid);
                    fail_cnt++;
                end
                if (e.last !== out_data.last)
                begin
                    $error("last exp %0d got %0d", e.last, out_data.last);
                    fail_cnt++;
                end
            end
        end
    end

    initial
    begin
        #4000000;
        $display("Verification failed");
        $finish;
    end
endmodule

// File: filelist.f
hw/rtl/dlgc_pkg.sv
hw/rtl/dlgc_node_cell.sv
hw/rtl/dlgc_color_cell.sv
hw/rtl/dsatur_limited_graph_coloring_unit.sv
tb/tb_top.sv
